### sv/rlbp_pkg.sv
// Shared types, constants and record formatting for the run-length bit packer.
package rlbp_pkg;

  localparam int COEF_W      = 11;
  localparam int MAG_W       = 10;
  localparam int LEN_FIELD_W = 6;
  localparam int REC_W       = 1 + LEN_FIELD_W + MAG_W;
  localparam int BYTE_W      = 8;
  localparam int ACC_W       = (BYTE_W - 1) + REC_W;
  localparam int ACC_CNT_W   = $clog2(ACC_W + 1);
  localparam int QUEUE_DEPTH = 4;

  typedef logic [COEF_W-1:0]      coef_t;
  typedef logic [LEN_FIELD_W-1:0] len_field_t;
  typedef logic [REC_W-1:0]       rec_t;

  // Work for the back end from one coefficient: a record closed by a value
  // change, and the final record of the block followed by a flush.
  typedef struct packed {
    logic brk_valid;
    rec_t brk_rec;
    logic end_valid;
    rec_t end_rec;
  } entry_t;

  // Build sign, length field and saturated magnitude of one run.
  function automatic rec_t make_rec(coef_t value, len_field_t len_field);
    coef_t              neg;
    logic [MAG_W-1:0]   mag;
    neg = coef_t'(~value + coef_t'(1));
    if (value[COEF_W-1]) begin
      mag = neg[COEF_W-1] ? {MAG_W{1'b1}} : neg[MAG_W-1:0];
    end else begin
      mag = value[MAG_W-1:0];
    end
    return {value[COEF_W-1], len_field, mag};
  endfunction

endpackage

### sv/rlbp_front.sv
// Front end: tracks runs and block position, emits closed records to the queue.
module rlbp_front #(
  parameter int BLOCK_SIDE = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rlbp_pkg::coef_t coef,
  input  logic            q_full,
  output logic            q_push,
  output rlbp_pkg::entry_t q_entry
);
  import rlbp_pkg::*;

  localparam int BLOCK_LEN = BLOCK_SIDE * BLOCK_SIDE;
  localparam int POS_W     = $clog2(BLOCK_LEN);
  localparam int LEN_W     = POS_W + 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_LEN - 1);

  coef_t            run_value;
  logic [LEN_W-1:0] run_length;
  logic [POS_W-1:0] block_position;

  logic             accept;
  logic             first;
  logic             brk;
  logic             is_last;
  logic [LEN_W-1:0] new_len;

  always_comb begin
    in_ready = !q_full;
    accept   = in_valid && !q_full;
    first    = (block_position == '0);
    brk      = !first && (coef != run_value);
    is_last  = (block_position == LAST_POS);
    new_len  = (first || brk) ? LEN_W'(1) : LEN_W'(run_length + LEN_W'(1));

    q_entry.brk_valid = brk;
    q_entry.brk_rec   = make_rec(run_value, LEN_FIELD_W'(run_length - LEN_W'(1)));
    q_entry.end_valid = is_last;
    q_entry.end_rec   = make_rec(coef, LEN_FIELD_W'(new_len - LEN_W'(1)));
    q_push            = accept && (brk || is_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value      <= '0;
      run_length     <= '0;
      block_position <= '0;
    end else if (accept) begin
      if (is_last) begin
        run_value      <= '0;
        run_length     <= '0;
        block_position <= '0;
      end else begin
        run_value      <= coef;
        run_length     <= new_len;
        block_position <= block_position + POS_W'(1);
      end
    end
  end

endmodule

### sv/rlbp_queue.sv
// Short FIFO of record work between the front and back ends.
module rlbp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rlbp_pkg::entry_t  wr_data,
  output logic              full,
  output logic              rd_valid,
  input  logic              pop,
  output rlbp_pkg::entry_t  rd_data
);
  import rlbp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  entry_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  always_comb begin
    full     = (fill == CNT_W'(QUEUE_DEPTH));
    rd_valid = (fill != '0);
    rd_data  = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

### sv/rlbp_back.sv
// Back end: buffers record bits and drains one byte per cycle unless stalled.
module rlbp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_pop,
  input  rlbp_pkg::entry_t q_entry,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last
);
  import rlbp_pkg::*;

  logic                 pend_a;
  logic                 pend_b;
  rec_t                 rec_a;
  rec_t                 rec_b;
  logic                 flush;
  logic [ACC_W-1:0]     acc;
  logic [ACC_CNT_W-1:0] cnt;

  logic                 idle;
  logic                 full_byte;
  logic                 can_emit;
  logic                 do_append;
  logic [ACC_CNT_W-1:0] cnt_next;
  logic [BYTE_W-1:0]    byte_next;
  logic                 last_next;

  always_comb begin
    idle      = !pend_a && !pend_b && !flush;
    q_pop     = idle && q_valid;
    full_byte = (cnt >= ACC_CNT_W'(BYTE_W));
    can_emit  = (!out_valid || out_ready) && (full_byte || (flush && cnt != '0));
    do_append = !full_byte && (pend_a || pend_b);
    if (full_byte) begin
      cnt_next  = cnt - ACC_CNT_W'(BYTE_W);
      byte_next = BYTE_W'(acc >> cnt_next);
      last_next = flush && (cnt_next == '0);
    end else begin
      // pad the tail of the block with zeros
      cnt_next  = '0;
      byte_next = BYTE_W'(acc << (ACC_CNT_W'(BYTE_W) - cnt));
      last_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_a    <= 1'b0;
      pend_b    <= 1'b0;
      flush     <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        pend_a <= q_entry.brk_valid;
        pend_b <= q_entry.end_valid;
      end else if (do_append) begin
        if (pend_a) begin
          pend_a <= 1'b0;
        end else begin
          pend_b <= 1'b0;
          flush  <= 1'b1;
        end
      end
      if (do_append) begin
        cnt <= cnt + ACC_CNT_W'(REC_W);
      end else if (can_emit) begin
        cnt <= cnt_next;
        if (cnt_next == '0) begin
          flush <= 1'b0;
        end
      end
      if (can_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_a <= q_entry.brk_rec;
      rec_b <= q_entry.end_rec;
    end
    if (do_append) begin
      acc <= ACC_W'({acc, (pend_a ? rec_a : rec_b)});
    end
    if (can_emit) begin
      out_byte <= byte_next;
      out_last <= last_next;
    end
  end

endmodule

### sv/run_length_bit_packer.sv
// Top level of the run-length bit packer: front end, record queue, byte packer.
//
//  channel   dir   payload                               completes when
//  s_*       in    s_tdata[10:0] coefficient (signed)    s_tvalid & s_tready
//  m_*       out   m_tdata[7:0] packed_byte, m_tlast     m_tvalid & m_tready
//
// A coefficient enters every cycle while the record queue has room.
// Each record is appended to the bit buffer and drained as two or three
// bytes before the next is appended, so a block whose every coefficient
// closes a run is paced by the single byte port of the packer.
// Reset (rst, synchronous, active high) empties the queue and starts a block.
// m_tready low stalls only the packer; the front keeps taking coefficients
// until the queue fills.
module run_length_bit_packer #(
  parameter int BLOCK_SIDE = 8
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [10:0] coefficient, [15:11] zero fill
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] packed_byte, earliest bit in bit 7
  output logic        m_tlast    // block_end: last byte, padded as needed
);
  import rlbp_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  entry_t q_wr;
  entry_t q_rd;

  // Classify each coefficient: extend the open run, or close it into a record.
  rlbp_front #(
    .BLOCK_SIDE(BLOCK_SIDE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .coef     (s_tdata[COEF_W-1:0]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_wr)
  );

  // Hold closed records so both sides stall independently.
  rlbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .rd_valid (q_valid),
    .pop      (q_pop),
    .rd_data  (q_rd)
  );

  // Pack records MSB first into bytes behind a registered output.
  rlbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_rd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
